/* hw/rtl/wcd_pkg.sv */
// Shared types and constants for the windowed consecutive dedup block.
package wcd_pkg;

  localparam int unsigned DistBits  = 32;
  localparam logic [31:0] DistMask  = (DistBits >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << DistBits) - 64'd1);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrBits   = $clog2(FifoDepth);
  localparam int unsigned CntBits   = $clog2(FifoDepth + 1);

  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegMergeMode   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegMergeWindow = 2'd1;

  typedef enum logic [1:0] {
    ModeNone        = 2'd0,
    ModeKeepFirst   = 2'd1,
    ModeKeepLast    = 2'd2,
    ModeKeepClosest = 2'd3
  } merge_mode_e;

  typedef struct packed {
    logic        [31:0] id;
    logic        [31:0] route;
    logic        [31:0] off;
    logic        [31:0] price;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
  } rec_t;

  typedef struct packed {
    rec_t rec;
    logic last;
  } result_t;

  // Results produced by one accepted record, in emission order.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

/* hw/rtl/wcd_merge.sv */
// Held record, configuration registers and the per-record merge decision.
module wcd_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [wcd_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            accept_i,
  input  wcd_pkg::rec_t                   rec_i,
  input  logic                            last_i,
  output wcd_pkg::push_t                  push_o
);
  import wcd_pkg::*;

  merge_mode_e        mode_q;
  logic [31:0]        window_q;
  logic               held_valid_q, held_valid_d;
  rec_t               held_q, held_d;

  rec_t               cur;
  rec_t               next_held;
  logic               merge;
  logic signed [33:0] diff;
  logic signed [33:0] win;

  always_comb begin
    cur       = rec_i;
    cur.route = rec_i.route & DistMask;
    cur.off   = rec_i.off & DistMask;
  end

  // Exact signed difference; a record behind the held one always falls in the window.
  assign diff  = $signed({2'b00, cur.route}) - $signed({2'b00, held_q.route});
  assign win   = $signed({2'b00, window_q});
  assign merge = (cur.id == held_q.id) && (diff < win);

  always_comb begin
    push_o       = '0;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    next_held    = held_q;
    if (mode_q == ModeNone) begin
      held_valid_d = 1'b0;
      if (held_valid_q) begin
        push_o.num    = 2'd2;
        push_o.first  = '{rec: held_q, last: 1'b0};
        push_o.second = '{rec: cur, last: last_i};
      end else begin
        push_o.num   = 2'd1;
        push_o.first = '{rec: cur, last: last_i};
      end
    end else begin
      if (!held_valid_q) begin
        next_held = cur;
      end else if (merge) begin
        if (mode_q == ModeKeepLast ||
            (mode_q == ModeKeepClosest && cur.off < held_q.off)) begin
          next_held = cur;
        end
      end else begin
        push_o.num   = 2'd1;
        push_o.first = '{rec: held_q, last: 1'b0};
        next_held    = cur;
      end
      held_d       = next_held;
      held_valid_d = 1'b1;
      // Flush on end of list into the next free slot.
      if (last_i) begin
        held_valid_d = 1'b0;
        if (push_o.num == 2'd0) begin
          push_o.num   = 2'd1;
          push_o.first = '{rec: next_held, last: 1'b1};
        end else begin
          push_o.num    = 2'd2;
          push_o.second = '{rec: next_held, last: 1'b1};
        end
      end
    end
    if (!accept_i) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeNone;
      window_q     <= '0;
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegMergeMode:   mode_q   <= merge_mode_e'(cfg_data_i[1:0]);
          RegMergeWindow: window_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        held_valid_q <= held_valid_d;
        held_q       <= held_d;
      end
    end
  end

endmodule

/* hw/rtl/wcd_out_fifo.sv */
// Result queue: takes up to two results per cycle, delivers one per transfer.
module wcd_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wcd_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output wcd_pkg::result_t out_o
);
  import wcd_pkg::*;

  result_t              mem_q [FifoDepth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   count_q;
  logic                 pop;
  logic [PtrBits-1:0]   wr_ptr_nx;

  assign out_valid_o = (count_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Keep space for the worst case of two results from the next record.
  assign room_o      = (count_q <= CntBits'(FifoDepth - 2));
  assign wr_ptr_nx   = wr_ptr_q + PtrBits'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrBits'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      end
      count_q <= count_q + CntBits'(push_i.num) - CntBits'(pop);
    end
  end

endmodule

/* hw/rtl/windowed_consecutive_dedup.sv */
// Windowed consecutive dedup: merges same-id neighbor records within a distance window.
//
// Input channel: in_valid_i / in_stall_o with one record per transfer. The block
// holds the last kept record; a record with the same id whose route distance minus
// the held distance is below merge_window merges per merge_mode (keep first, keep
// last, keep closest). A non-merging record emits the held one; end_of_list_i
// flushes the held record with final_result_o set. Mode none passes records through.
// Output channel: out_valid_o / out_stall_i, one result per transfer.
// Configuration: cfg_valid_i / cfg_ready_o (always ready), index 0 merge_mode,
// index 1 merge_window; write only while idle.
// Each result is written into the result queue when the record that causes it is
// accepted. Input takes one record per cycle while the queue has room; a record
// that causes two results leaves as two transfers on the single-result output port.
// A four-entry result queue decouples the sides: input stalls when fewer than two
// entries are free, so a stalled receiver backs up into in_stall_o after a few
// records. Reset empties the queue, drops the held record and clears both registers.
module windowed_consecutive_dedup (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    record_id_i,
  input  logic [31:0]                    route_distance_i,
  input  logic [31:0]                    offset_distance_i,
  input  logic [31:0]                    unit_price_i,
  input  logic signed [31:0]             snap_lat_i,
  input  logic signed [31:0]             snap_lon_i,
  input  logic                           end_of_list_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    out_id_o,
  output logic [31:0]                    out_route_distance_o,
  output logic [31:0]                    out_offset_distance_o,
  output logic [31:0]                    out_price_o,
  output logic signed [31:0]             out_lat_o,
  output logic signed [31:0]             out_lon_o,
  output logic                           final_result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wcd_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import wcd_pkg::*;

  rec_t    in_rec;
  push_t   push;
  result_t res;
  logic    room;
  logic    accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room;
  assign accept      = in_valid_i && room;

  assign in_rec = '{id: record_id_i, route: route_distance_i, off: offset_distance_i,
                    price: unit_price_i, lat: snap_lat_i, lon: snap_lon_i};

  wcd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .rec_i       (in_rec),
    .last_i      (end_of_list_i),
    .push_o      (push)
  );

  wcd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign out_id_o              = res.rec.id;
  assign out_route_distance_o  = res.rec.route;
  assign out_offset_distance_o = res.rec.off;
  assign out_price_o           = res.rec.price;
  assign out_lat_o             = res.rec.lat;
  assign out_lon_o             = res.rec.lon;
  assign final_result_o        = res.last;

endmodule
